// ===== design/rtc_alarm_time_from_timeout_assert.svh =====
// Assertion macros shared by the RTL
`ifndef RTC_ALARM_TIME_FROM_TIMEOUT_ASSERT_SVH
`define RTC_ALARM_TIME_FROM_TIMEOUT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RATFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RATFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ratft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ratft_pkg;

    localparam int PC_W = 5;
    localparam int K_W  = 5;
    localparam int Q_W  = 22;
    localparam int F_W  = 7;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_DSTEP,
        OP_TICK,
        OP_ADDQ,
        OP_ADDR,
        OP_LOADA,
        OP_STORE,
        OP_SKIPLE,
        OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        D_250,
        D_DAY,
        D_HOUR,
        D_MIN,
        D_24,
        D_LEN
    } t_dsel;

    typedef enum logic [2:0] {
        C_NONE,
        C_T,
        C_DAY,
        C_HOUR,
        C_MIN,
        C_2
    } t_csel;

    typedef enum logic [1:0] {
        F_SEC,
        F_MIN,
        F_HR,
        F_DAY
    } t_fsel;

    typedef struct packed {
        t_op            op;
        t_dsel          dsel;
        t_csel          csel;
        t_fsel          fsel;
        logic [PC_W-1:0] target;
    } t_ctrl;

    localparam logic [PC_W-1:0] PC_OUT = PC_W'(26);

    function automatic t_ctrl mk(t_op op, t_dsel d, t_csel c, t_fsel f, logic [PC_W-1:0] t);
        t_ctrl w;
        w.op     = op;
        w.dsel   = d;
        w.csel   = c;
        w.fsel   = f;
        w.target = t;
        return w;
    endfunction

    // control store
    function automatic t_ctrl ucode(logic [PC_W-1:0] pc);
        t_ctrl w;
        w = mk(OP_IDLE, D_250, C_NONE, F_SEC, '0);
        case (pc)
            5'd0:  w = mk(OP_IDLE,   D_250,  C_T,    F_SEC, '0);
            5'd1:  w = mk(OP_DSTEP,  D_250,  C_NONE, F_SEC, '0);
            5'd2:  w = mk(OP_TICK,   D_250,  C_DAY,  F_SEC, '0);
            5'd3:  w = mk(OP_DSTEP,  D_DAY,  C_NONE, F_SEC, '0);
            5'd4:  w = mk(OP_ADDQ,   D_DAY,  C_HOUR, F_DAY, '0);
            5'd5:  w = mk(OP_DSTEP,  D_HOUR, C_NONE, F_SEC, '0);
            5'd6:  w = mk(OP_ADDQ,   D_HOUR, C_MIN,  F_HR,  '0);
            5'd7:  w = mk(OP_DSTEP,  D_MIN,  C_NONE, F_SEC, '0);
            5'd8:  w = mk(OP_ADDQ,   D_MIN,  C_NONE, F_MIN, '0);
            5'd9:  w = mk(OP_ADDR,   D_MIN,  C_NONE, F_SEC, '0);
            5'd10: w = mk(OP_LOADA,  D_MIN,  C_2,    F_SEC, '0);
            5'd11: w = mk(OP_DSTEP,  D_MIN,  C_NONE, F_SEC, '0);
            5'd12: w = mk(OP_STORE,  D_MIN,  C_NONE, F_SEC, '0);
            5'd13: w = mk(OP_ADDQ,   D_MIN,  C_NONE, F_MIN, '0);
            5'd14: w = mk(OP_LOADA,  D_MIN,  C_2,    F_MIN, '0);
            5'd15: w = mk(OP_DSTEP,  D_MIN,  C_NONE, F_SEC, '0);
            5'd16: w = mk(OP_STORE,  D_MIN,  C_NONE, F_MIN, '0);
            5'd17: w = mk(OP_ADDQ,   D_MIN,  C_NONE, F_HR,  '0);
            5'd18: w = mk(OP_LOADA,  D_24,   C_2,    F_HR,  '0);
            5'd19: w = mk(OP_DSTEP,  D_24,   C_NONE, F_SEC, '0);
            5'd20: w = mk(OP_STORE,  D_24,   C_NONE, F_HR,  '0);
            5'd21: w = mk(OP_ADDQ,   D_24,   C_NONE, F_DAY, '0);
            5'd22: w = mk(OP_SKIPLE, D_LEN,  C_2,    F_DAY, PC_OUT);
            5'd23: w = mk(OP_LOADA,  D_LEN,  C_NONE, F_DAY, '0);
            5'd24: w = mk(OP_DSTEP,  D_LEN,  C_NONE, F_SEC, '0);
            5'd25: w = mk(OP_STORE,  D_LEN,  C_NONE, F_DAY, '0);
            5'd26: w = mk(OP_OUT,    D_LEN,  C_NONE, F_SEC, '0);
            default: w = mk(OP_IDLE, D_250,  C_NONE, F_SEC, '0);
        endcase
        return w;
    endfunction

    function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
        logic [4:0] d;
        unique case (month)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/rtc_alarm_time_from_timeout.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One word is in flight at a time; every divide uses the shared restoring divider
//   (one quotient bit per cycle, 22 bits for the tick conversion).
// The result register frees the input side while a result waits downstream.
// Reset (i_rst_n low, synchronous) clears the error accumulator, sequencer and valid.

`include "rtc_alarm_time_from_timeout_assert.svh"

module rtc_alarm_time_from_timeout #(
    parameter int MAX_ALARM_DAYS = 28
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // timeout_ms, now_seconds, now_minutes, now_hours, now_date, now_month,
    // now_year, century_base, zero pad
    input  wire  [87:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // alarm_seconds, alarm_minutes, alarm_hours, alarm_date, tick_total, zero pad
    output logic [47:0] o_m_tdata
);

    localparam int MAX_MS = (MAX_ALARM_DAYS * 86400 * 125) / 256;
    localparam int MS_W   = $clog2(MAX_MS + 1);
    localparam int TW     = $clog2(MAX_ALARM_DAYS * 86400 + 2);
    localparam int DW     = $clog2(MAX_ALARM_DAYS + 1);

    localparam int ACC_CORR = 488;

    ratft_pkg::t_ctrl              ctl;
    logic [ratft_pkg::PC_W-1:0]    r_pc, n_pc;
    logic [ratft_pkg::K_W-1:0]     r_k, n_k;
    logic [ratft_pkg::Q_W-1:0]     r_q, n_q;
    logic [31:0]                   r_a, n_a;
    logic signed [31:0]            r_accum, n_accum;
    logic [TW-1:0]                 r_ticks, n_ticks;
    logic [ratft_pkg::F_W-1:0]     r_sec, n_sec, r_min, n_min, r_hr, n_hr, r_day, n_day;
    logic [4:0]                    r_len, n_len;
    logic                          r_ovalid, n_ovalid;
    logic [47:0]                   r_odata, n_odata;

    logic [31:0]                   in_ms;
    logic [MS_W-1:0]               ms_c;
    logic                          leap;
    logic [1:0]                    ysum;
    logic [16:0]                   dv;
    logic [31:0]                   dv_sh;
    logic                          ge;
    logic [ratft_pkg::K_W-1:0]     k_init;
    logic [ratft_pkg::F_W-1:0]     fld;
    logic signed [10:0]            err;
    logic [32:0]                   sum33;
    logic signed [31:0]            sat;
    logic [TW-1:0]                 tick_c;
    logic                          accept;
    logic                          out_ok;

    assign ctl        = ratft_pkg::ucode(r_pc);
    assign o_s_tready = (ctl.op == ratft_pkg::OP_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign out_ok     = !r_ovalid || i_m_tready;

    assign in_ms = i_s_tdata[31:0];
    assign ms_c  = (in_ms > 32'(MAX_MS)) ? MS_W'(MAX_MS) :
                   ((in_ms == 32'd0) ? MS_W'(1) : in_ms[MS_W-1:0]);
    assign ysum  = i_s_tdata[59:58] + i_s_tdata[66:65];
    assign leap  = (i_s_tdata[64:58] == 7'd0) || (ysum == 2'd0);

    always_comb begin
        unique case (ctl.dsel)
            ratft_pkg::D_250:  dv = 17'd250;
            ratft_pkg::D_DAY:  dv = 17'd86400;
            ratft_pkg::D_HOUR: dv = 17'd3600;
            ratft_pkg::D_MIN:  dv = 17'd60;
            ratft_pkg::D_24:   dv = 17'd24;
            ratft_pkg::D_LEN:  dv = {12'd0, r_len};
            default:           dv = 17'd250;
        endcase
    end

    assign dv_sh = 32'(dv) << r_k;
    assign ge    = (r_a >= dv_sh);

    always_comb begin
        unique case (ctl.csel)
            ratft_pkg::C_T:    k_init = ratft_pkg::K_W'(TW - 1);
            ratft_pkg::C_DAY:  k_init = ratft_pkg::K_W'(DW - 1);
            ratft_pkg::C_HOUR: k_init = ratft_pkg::K_W'(4);
            ratft_pkg::C_MIN:  k_init = ratft_pkg::K_W'(5);
            ratft_pkg::C_2:    k_init = ratft_pkg::K_W'(1);
            default:           k_init = r_k;
        endcase
    end

    always_comb begin
        unique case (ctl.fsel)
            ratft_pkg::F_SEC: fld = r_sec;
            ratft_pkg::F_MIN: fld = r_min;
            ratft_pkg::F_HR:  fld = r_hr;
            default:          fld = r_day;
        endcase
    end

    // rounding error of the conversion is 500 - 4*remainder
    assign err   = 11'sd500 - $signed({1'b0, r_a[7:0], 2'b00});
    assign sum33 = {r_accum[31], r_accum} + {{22{err[10]}}, err};
    always_comb begin
        if (sum33[32] != sum33[31]) begin
            sat = sum33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat = $signed(sum33[31:0]);
        end
    end
    assign tick_c = r_q[TW-1:0] + TW'(1);

    always_comb begin
        n_pc     = r_pc;
        n_k      = r_k;
        n_q      = r_q;
        n_a      = r_a;
        n_accum  = r_accum;
        n_ticks  = r_ticks;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hr     = r_hr;
        n_day    = r_day;
        n_len    = r_len;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !i_m_tready;

        if (ctl.csel != ratft_pkg::C_NONE) begin
            n_k = k_init;
            n_q = '0;
        end

        unique case (ctl.op)
            ratft_pkg::OP_IDLE: begin
                if (accept) begin
                    n_a   = (32'(ms_c) << 9) + 32'd125;
                    n_sec = ratft_pkg::F_W'(i_s_tdata[37:32]);
                    n_min = ratft_pkg::F_W'(i_s_tdata[43:38]);
                    n_hr  = ratft_pkg::F_W'(i_s_tdata[48:44]);
                    n_day = ratft_pkg::F_W'(i_s_tdata[53:49]);
                    n_len = ratft_pkg::month_days(i_s_tdata[57:54], leap);
                    n_pc  = r_pc + 1'b1;
                end
            end
            ratft_pkg::OP_DSTEP: begin
                n_q = {r_q[ratft_pkg::Q_W-2:0], ge};
                if (ge) begin
                    n_a = r_a - dv_sh;
                end
                if (r_k == '0) begin
                    n_pc = r_pc + 1'b1;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            ratft_pkg::OP_TICK: begin
                if (sat >= 32'sd488) begin
                    n_accum = sat - 32'(ACC_CORR);
                    n_ticks = tick_c;
                end else begin
                    n_accum = sat;
                    n_ticks = r_q[TW-1:0];
                end
                n_a  = 32'(n_ticks);
                n_pc = r_pc + 1'b1;
            end
            ratft_pkg::OP_ADDQ, ratft_pkg::OP_ADDR, ratft_pkg::OP_STORE: begin
                logic [ratft_pkg::F_W-1:0] v;
                if (ctl.op == ratft_pkg::OP_ADDQ) begin
                    v = fld + r_q[ratft_pkg::F_W-1:0];
                end else if (ctl.op == ratft_pkg::OP_ADDR) begin
                    v = fld + r_a[ratft_pkg::F_W-1:0];
                end else begin
                    v = r_a[ratft_pkg::F_W-1:0];
                end
                case (ctl.fsel)
                    ratft_pkg::F_SEC: n_sec = v;
                    ratft_pkg::F_MIN: n_min = v;
                    ratft_pkg::F_HR:  n_hr  = v;
                    default:          n_day = v;
                endcase
                n_pc = r_pc + 1'b1;
            end
            ratft_pkg::OP_LOADA: begin
                n_a  = 32'(fld);
                n_pc = r_pc + 1'b1;
            end
            ratft_pkg::OP_SKIPLE: begin
                if (r_day <= ratft_pkg::F_W'(r_len)) begin
                    n_pc = ctl.target;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end
            ratft_pkg::OP_OUT: begin
                if (out_ok) begin
                    n_odata  = {4'd0, 22'(r_ticks), r_day[4:0], r_hr[4:0],
                                r_min[5:0], r_sec[5:0]};
                    n_ovalid = 1'b1;
                    n_pc     = '0;
                end
            end
            default: begin
                n_pc = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_accum  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_pc     <= n_pc;
            r_accum  <= n_accum;
            r_ovalid <= n_ovalid;
        end
        r_k     <= n_k;
        r_q     <= n_q;
        r_a     <= n_a;
        r_ticks <= n_ticks;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hr    <= n_hr;
        r_day   <= n_day;
        r_len   <= n_len;
        r_odata <= n_odata;
    end

    `RATFT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_pc == ratft_pkg::PC_W'(1), "accept did not start the program")
    `RATFT_ASSERT_NOW(a_rem_range, i_clk, i_rst_n, ctl.op == ratft_pkg::OP_TICK, r_a < 32'd250, "conversion remainder out of range")
    `RATFT_ASSERT_NOW(a_fields_range, i_clk, i_rst_n, ctl.op == ratft_pkg::OP_OUT, (r_sec < 7'd60) && (r_min < 7'd60) && (r_hr < 7'd24), "time field out of range at output")
    `RATFT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result word changed while stalled")

endmodule

`default_nettype wire
